// File: hw/rtl/fpa_pkg.sv
// Shared codes and handoff types for the fixed partition allocator.
`default_nettype none

package fpa_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PLACE  = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;

  localparam logic [2:0] STAT_PLACED  = 3'd0;
  localparam logic [2:0] STAT_NO_FIT  = 3'd1;
  localparam logic [2:0] STAT_ADDED   = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  // Control part of the search request that walks down the row of cells.
  typedef struct packed {
    logic       active;
    logic       found;
    logic [1:0] policy;
  } fpa_scan_t;

  // Table update broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic wr_en;
    logic mark_en;
  } fpa_cmd_t;

  // The high bit selects an operation or policy; the upper code folds onto it.
  function automatic logic op_is_place(input logic [1:0] op);
    return op[1];
  endfunction

  function automatic logic pol_is_best(input logic [1:0] pol);
    return pol[1];
  endfunction

  function automatic logic pol_is_worst(input logic [1:0] pol);
    return (pol == POL_WORST);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fpa_cell.sv
// One partition entry of the allocator row, with its search stage.
`default_nettype none

module fpa_cell
  import fpa_pkg::*;
#(
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_WIDTH  = 4,
  parameter int CNT_WIDTH  = 5,
  parameter int IDX        = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  fpa_cmd_t              cmd_i,
  input  wire [IDX_WIDTH-1:0]   wr_idx_i,
  input  wire [SIZE_WIDTH-1:0]  wr_size_i,
  input  wire [IDX_WIDTH-1:0]   mark_idx_i,
  input  wire [CNT_WIDTH-1:0]   count_i,
  input  fpa_scan_t             scan_i,
  input  wire [SIZE_WIDTH-1:0]  req_i,
  input  wire [IDX_WIDTH-1:0]   pick_idx_i,
  input  wire [SIZE_WIDTH-1:0]  pick_size_i,
  output fpa_scan_t             scan_o,
  output logic [SIZE_WIDTH-1:0] req_o,
  output logic [IDX_WIDTH-1:0]  pick_idx_o,
  output logic [SIZE_WIDTH-1:0] pick_size_o
);

  logic [SIZE_WIDTH-1:0] size_q;
  logic                  taken_q;
  fpa_scan_t             scan_q;
  logic [SIZE_WIDTH-1:0] req_q;
  logic [IDX_WIDTH-1:0]  pick_idx_q;
  logic [SIZE_WIDTH-1:0] pick_size_q;

  logic entry_free;
  logic fits;
  logic take;
  logic wr_hit;
  logic mark_hit;

  assign entry_free = (CNT_WIDTH'(IDX) < count_i) && !taken_q;
  assign fits       = (size_q >= req_i);
  assign wr_hit     = cmd_i.wr_en && (wr_idx_i == IDX_WIDTH'(IDX));
  assign mark_hit   = cmd_i.mark_en && (mark_idx_i == IDX_WIDTH'(IDX));

  always_comb begin
    take = 1'b0;
    if (scan_i.active && entry_free) begin
      if (pol_is_best(scan_i.policy)) begin
        take = fits && (!scan_i.found || size_q < pick_size_i);
      end else if (pol_is_worst(scan_i.policy)) begin
        // largest so far; the fit test is made at the tail of the row
        take = !scan_i.found || size_q > pick_size_i;
      end else begin
        take = fits && !scan_i.found;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      if (cmd_i.clear || wr_hit) begin
        taken_q <= 1'b0;
      end else if (mark_hit) begin
        taken_q <= 1'b1;
      end
      scan_q.active <= scan_i.active;
      scan_q.policy <= scan_i.policy;
      scan_q.found  <= scan_i.found || take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      size_q <= wr_size_i;
    end
    req_q <= req_i;
    if (take) begin
      pick_idx_q  <= IDX_WIDTH'(IDX);
      pick_size_q <= size_q;
    end else begin
      pick_idx_q  <= pick_idx_i;
      pick_size_q <= pick_size_i;
    end
  end

  assign scan_o      = scan_q;
  assign req_o       = req_q;
  assign pick_idx_o  = pick_idx_q;
  assign pick_size_o = pick_size_q;

endmodule

`default_nettype wire

// File: hw/rtl/fixed_partition_allocator.sv
// Top level of the fixed partition allocator: control, table row and result register.
//
// Usage: requests arrive on the s_axis channel, operation in tuser, size in
// tdata. Each request yields exactly one result on m_axis: status in tuser,
// partition index and leftover in tdata. fit_policy is written through
// cfg_we_i / cfg_wdata_i while the block is idle.
// For clear and append the result is registered and valid the
// cycle after the request is taken.
// A place request walks the row of MAX_PARTITIONS cells, one cell per clock,
// carrying the best candidate so far; its result is registered when the
// request leaves the tail of the row, and no new request is taken until
// then. The row length sets how long a place lasts.
// Requests are taken only when the result register is empty or being drained;
// a stalled receiver holds m_axis and in turn holds off s_axis.
// Reset empties the table, clears all taken marks, selects first fit and
// drops any pending result. Partition sizes are not reset; only appended
// entries are ever read.
`default_nettype none

module fixed_partition_allocator
  import fpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_WIDTH     = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // size_value[15:0]
  input  wire  [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // partition_index[3:0], leftover[19:4], zero pad
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int IDX_WIDTH = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_WIDTH = $clog2(MAX_PARTITIONS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_WIDTH-1:0] count_q, count_d;
  logic [1:0]           policy_q;
  logic                 m_valid_q, m_valid_d;
  logic [2:0]           m_status_q, m_status_d;
  logic [3:0]           m_idx_q, m_idx_d;
  logic [15:0]          m_left_q, m_left_d;

  fpa_cmd_t              cmd;
  logic [IDX_WIDTH-1:0]  mark_idx;
  logic [SIZE_WIDTH-1:0] in_size;
  logic                  s_fire;
  logic                  out_free;
  logic                  table_full;

  fpa_scan_t             scan_c      [MAX_PARTITIONS+1];
  logic [SIZE_WIDTH-1:0] req_c       [MAX_PARTITIONS+1];
  logic [IDX_WIDTH-1:0]  pick_idx_c  [MAX_PARTITIONS+1];
  logic [SIZE_WIDTH-1:0] pick_size_c [MAX_PARTITIONS+1];

  logic                  tail_hit;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_size       = SIZE_WIDTH'(s_axis_tdata);
  assign table_full    = (count_q == CNT_WIDTH'(MAX_PARTITIONS));

  // inject the search request at the head of the row
  assign scan_c[0].active = s_fire && op_is_place(s_axis_tuser);
  assign scan_c[0].found  = 1'b0;
  assign scan_c[0].policy = policy_q;
  assign req_c[0]         = in_size;
  assign pick_idx_c[0]    = '0;
  assign pick_size_c[0]   = '0;

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    fpa_cell #(
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_WIDTH  (IDX_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wr_idx_i    (count_q[IDX_WIDTH-1:0]),
      .wr_size_i   (in_size),
      .mark_idx_i  (mark_idx),
      .count_i     (count_q),
      .scan_i      (scan_c[g]),
      .req_i       (req_c[g]),
      .pick_idx_i  (pick_idx_c[g]),
      .pick_size_i (pick_size_c[g]),
      .scan_o      (scan_c[g+1]),
      .req_o       (req_c[g+1]),
      .pick_idx_o  (pick_idx_c[g+1]),
      .pick_size_o (pick_size_c[g+1])
    );
  end

  // worst fit may carry a candidate too small for the request; reject it here
  assign tail_hit = scan_c[MAX_PARTITIONS].found &&
                    (pick_size_c[MAX_PARTITIONS] >= req_c[MAX_PARTITIONS]);
  assign mark_idx = pick_idx_c[MAX_PARTITIONS];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_idx_d    = m_idx_q;
    m_left_d   = m_left_q;
    cmd        = '0;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (op_is_place(s_axis_tuser)) begin
            state_d = S_SCAN;
          end else if (s_axis_tuser == OP_APPEND) begin
            m_valid_d = 1'b1;
            m_left_d  = '0;
            if (table_full) begin
              m_status_d = STAT_FULL;
              m_idx_d    = '0;
            end else begin
              cmd.wr_en  = 1'b1;
              count_d    = count_q + 1'b1;
              m_status_d = STAT_ADDED;
              m_idx_d    = 4'(count_q);
            end
          end else begin
            cmd.clear  = 1'b1;
            count_d    = '0;
            m_valid_d  = 1'b1;
            m_status_d = STAT_CLEARED;
            m_idx_d    = '0;
            m_left_d   = '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_c[MAX_PARTITIONS].active) begin
          state_d   = S_IDLE;
          m_valid_d = 1'b1;
          if (tail_hit) begin
            cmd.mark_en = 1'b1;
            m_status_d  = STAT_PLACED;
            m_idx_d     = 4'(pick_idx_c[MAX_PARTITIONS]);
            m_left_d    = 16'(pick_size_c[MAX_PARTITIONS] - req_c[MAX_PARTITIONS]);
          end else begin
            m_status_d = STAT_NO_FIT;
            m_idx_d    = '0;
            m_left_d   = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      policy_q  <= POL_FIRST;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_idx_q    <= m_idx_d;
    m_left_q   <= m_left_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {4'b0000, m_left_q, m_idx_q};

  // a search reaches the tail only while the controller is scanning
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_c[MAX_PARTITIONS].active |-> (state_q == S_SCAN))
    else $error("search request left the row outside a scan");

  // the result register is always empty when a search completes
  a_tail_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_c[MAX_PARTITIONS].active |-> !m_valid_q)
    else $error("search completed while a result was still pending");

  // a place request starts a scan and blocks further requests
  a_place_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op_is_place(s_axis_tuser)) |=> (state_q == S_SCAN && !s_axis_tready))
    else $error("place request did not start a scan");

  // the partition count never exceeds the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_WIDTH'(MAX_PARTITIONS))
    else $error("partition count beyond table size");

  // a marked partition lies within the filled part of the table
  a_mark_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mark_en |-> (CNT_WIDTH'(mark_idx) < count_q))
    else $error("mark outside the filled table");

endmodule

`default_nettype wire

// File: dv/fixed_partition_allocator_tb.sv
// Self-checking stream testbench for the fixed partition allocator with its own table predictor.
`timescale 1ns / 100ps

module fixed_partition_allocator_tb;
  import fpa_pkg::*;

  localparam int          N_PART         = 16;
  localparam int          SETTLE_CYCLES  = N_PART + 4;
  localparam int          N_RANDOM_ITEMS = 1600;
  localparam int          LIMIT_NS       = 4_000_000;
  // Upper codes that fold onto place and best fit through their high bit.
  localparam logic [1:0]  OP_PLACE_ALIAS = 2'd3;
  localparam logic [1:0]  POL_BEST_ALIAS = 2'd3;

  typedef enum logic [1:0] {
    REQ_ITEM,
    REQ_SET_POLICY,
    REQ_SETTLE
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [1:0]  op;      // policy code for REQ_SET_POLICY
    logic [15:0] size;
  } queued_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  index;
    logic [15:0] leftover;
  } table_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;   // size_value[15:0]
  logic [1:0]  s_axis_tuser = 2'd0;    // operation[1:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;           // partition_index[3:0], leftover[19:4], zero pad
  wire  [2:0]  m_axis_tuser;           // status[2:0]

  fixed_partition_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // Shadow of the partition table.
  logic [15:0]       part_size [N_PART];
  logic [N_PART-1:0] part_taken = '0;
  logic [4:0]        part_count = '0;
  logic [1:0]        fit_policy = POL_FIRST;

  queued_req_t    queued_requests[$];
  table_outcome_t awaited_outcomes[$];
  int             n_items_queued = 0;
  int             n_accepted = 0;
  int             n_done = 0;
  int             n_errors = 0;

  // Apply one request to the shadow table and return the result it yields.
  function automatic table_outcome_t table_response(input logic [1:0] op,
                                                    input logic [15:0] req);
    table_outcome_t r;
    logic           hit;
    logic [3:0]     pick;
    r.status   = STAT_CLEARED;
    r.index    = 4'd0;
    r.leftover = 16'd0;
    hit  = 1'b0;
    pick = 4'd0;
    if (op[1]) begin
      for (int i = 0; i < N_PART; i++) begin
        if (i < part_count && !part_taken[i]) begin
          if (fit_policy[1]) begin
            if (part_size[i] >= req && (!hit || part_size[i] < part_size[pick])) begin
              hit  = 1'b1;
              pick = 4'(i);
            end
          end else if (fit_policy == POL_WORST) begin
            // largest free entry first; size is checked afterwards
            if (!hit || part_size[i] > part_size[pick]) begin
              hit  = 1'b1;
              pick = 4'(i);
            end
          end else if (!hit && part_size[i] >= req) begin
            hit  = 1'b1;
            pick = 4'(i);
          end
        end
      end
      if (hit && part_size[pick] >= req) begin
        part_taken[pick] = 1'b1;
        r.status   = STAT_PLACED;
        r.index    = pick;
        r.leftover = part_size[pick] - req;
      end else begin
        r.status = STAT_NO_FIT;
      end
    end else if (op[0]) begin
      if (part_count >= N_PART) begin
        r.status = STAT_FULL;
      end else begin
        part_size[part_count[3:0]]  = req;
        part_taken[part_count[3:0]] = 1'b0;
        r.status   = STAT_ADDED;
        r.index    = part_count[3:0];
        part_count = part_count + 5'd1;
      end
    end else begin
      part_taken = '0;
      part_count = '0;
    end
    return r;
  endfunction

  // Sender: bursts of requests with random gaps; policy writes only when idle.
  int          burst_left = 1;
  int          gap_left = 0;
  int          quiet_cycles = 0;
  queued_req_t head;
  logic        drive_valid;
  logic        drive_we;
  logic [1:0]  drive_op;
  logic [1:0]  drive_pol;
  logic [15:0] drive_size;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'd0;
      s_axis_tuser  <= 2'd0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= 2'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_outcomes.push_back(table_response(s_axis_tuser, s_axis_tdata));
        n_accepted++;
      end
      if (n_accepted == n_done && !s_axis_tvalid) quiet_cycles++;
      else quiet_cycles = 0;

      if (!(s_axis_tvalid && !s_axis_tready)) begin
        drive_valid = 1'b0;
        drive_we    = 1'b0;
        drive_op    = s_axis_tuser;
        drive_size  = s_axis_tdata;
        drive_pol   = cfg_wdata_i;
        if (gap_left != 0) begin
          gap_left--;
        end else if (queued_requests.size() != 0) begin
          head = queued_requests[0];
          if (head.kind == REQ_ITEM) begin
            head        = queued_requests.pop_front();
            drive_valid = 1'b1;
            drive_op    = head.op;
            drive_size  = head.size;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 6);
              gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                       : $urandom_range(0, 3);
            end
          end else if (quiet_cycles >= SETTLE_CYCLES) begin
            // hold off until the block has drained, then write the policy
            head = queued_requests.pop_front();
            if (head.kind == REQ_SET_POLICY) begin
              drive_we   = 1'b1;
              drive_pol  = head.op;
              fit_policy = head.op;
            end
          end
        end
        s_axis_tvalid <= drive_valid;
        s_axis_tuser  <= drive_op;
        s_axis_tdata  <= drive_size;
        cfg_we_i      <= drive_we;
        cfg_wdata_i   <= drive_pol;
      end
    end
  end

  // Receiver: stall pattern whose mode is redrawn at random periodically.
  int             stall_tick = 0;
  logic [1:0]     stall_mode = 2'd0;
  logic           ready_now;
  table_outcome_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_tick    <= 0;
      stall_mode    <= 2'd0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, actual status %0d tdata 0x%06h",
                   $time, m_axis_tuser, m_axis_tdata);
          n_errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (m_axis_tuser !== want.status) begin
            $display("%0t ns: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[3:0] !== want.index) begin
            $display("%0t ns: partition_index mismatch: expected %0d, actual %0d",
                     $time, want.index, m_axis_tdata[3:0]);
            n_errors++;
          end
          if (m_axis_tdata[19:4] !== want.leftover) begin
            $display("%0t ns: leftover mismatch: expected %0d, actual %0d",
                     $time, want.leftover, m_axis_tdata[19:4]);
            n_errors++;
          end
          if (m_axis_tdata[23:20] !== 4'd0) begin
            $display("%0t ns: tdata pad mismatch: expected 0, actual 0x%0h",
                     $time, m_axis_tdata[23:20]);
            n_errors++;
          end
          n_done <= n_done + 1;
        end
      end

      case (stall_mode)
        2'd0: ready_now = 1'b1;
        2'd1: ready_now = ($urandom_range(0, 9) < 7);
        2'd2: ready_now = ((stall_tick % 7) >= 3);
        default: ready_now = ($urandom_range(0, 4) == 0);
      endcase
      m_axis_tready <= ready_now;
      stall_tick    <= stall_tick + 1;
      if ((stall_tick % 256) == 255) stall_mode <= 2'($urandom_range(0, 3));
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [15:0] size);
    queued_req_t q;
    q.kind = REQ_ITEM;
    q.op   = op;
    q.size = size;
    queued_requests.push_back(q);
    n_items_queued++;
  endtask

  task automatic queue_policy(input logic [1:0] pol);
    queued_req_t q;
    q.kind = REQ_SET_POLICY;
    q.op   = pol;
    q.size = 16'd0;
    queued_requests.push_back(q);
  endtask

  task automatic queue_settle();
    queued_req_t q;
    q.kind = REQ_SETTLE;
    q.op   = 2'd0;
    q.size = 16'd0;
    queued_requests.push_back(q);
  endtask

  function automatic logic [15:0] draw_size();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return 16'($urandom);
      4: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(1, 4095));
    endcase
  endfunction

  // Clear, fill the table (sometimes past full), then place against the sizes just added.
  task automatic queue_episode();
    logic [15:0] sizes [18];
    logic [15:0] base;
    logic [15:0] req;
    int          n_parts;
    int          n_places;
    n_parts  = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
    n_places = $urandom_range(1, n_parts + 3);
    queue_item(OP_CLEAR, 16'($urandom));
    for (int j = 0; j < n_parts; j++) begin
      sizes[j] = draw_size();
      // duplicate sizes exercise the lowest-index tie break
      if (j > 0 && $urandom_range(0, 4) == 0) sizes[j] = sizes[$urandom_range(0, j - 1)];
      queue_item(OP_APPEND, sizes[j]);
    end
    for (int k = 0; k < n_places; k++) begin
      base = sizes[$urandom_range(0, n_parts - 1)];
      case ($urandom_range(0, 9))
        0, 1: req = base;
        2: req = 16'($urandom);
        3: req = base + 16'($urandom_range(1, 3));
        default: req = 16'($urandom_range(0, base));
      endcase
      queue_item(($urandom_range(0, 5) == 0) ? OP_PLACE_ALIAS : OP_PLACE, req);
    end
    if ($urandom_range(0, 9) == 0) begin
      for (int k = 0; k < 4; k++) queue_item(2'($urandom_range(0, 3)), 16'($urandom));
    end
  endtask

  initial begin
    logic [1:0] policy_order [4];
    int         phase;
    int         phase_end;

    policy_order[0] = POL_WORST;
    policy_order[1] = POL_BEST;
    policy_order[2] = POL_BEST_ALIAS;
    policy_order[3] = POL_FIRST;

    // Directed: field extremes, full table, zero-size request, empty table.
    queue_item(OP_CLEAR, 16'hFFFF);
    queue_item(OP_APPEND, 16'hFFFF);
    queue_item(OP_APPEND, 16'h0000);
    queue_item(OP_APPEND, 16'h0001);
    for (int i = 3; i < N_PART; i++) queue_item(OP_APPEND, 16'(i * 5003));
    queue_item(OP_APPEND, 16'h0007);
    queue_item(OP_PLACE, 16'h0000);
    queue_item(OP_PLACE_ALIAS, 16'hFFFF);
    queue_item(OP_PLACE, 16'h0001);
    queue_item(OP_CLEAR, 16'h0000);
    queue_item(OP_PLACE, 16'h0005);

    phase = 0;
    while (n_items_queued < N_RANDOM_ITEMS) begin
      queue_policy((phase < 4) ? policy_order[phase] : 2'($urandom_range(0, 3)));
      phase_end = n_items_queued + $urandom_range(120, 260);
      while (n_items_queued < phase_end && n_items_queued < N_RANDOM_ITEMS) begin
        queue_episode();
        if ($urandom_range(0, 15) == 0) queue_settle();
      end
      phase++;
    end

    wait (rst_ni === 1'b1);
    while (queued_requests.size() != 0 || s_axis_tvalid || n_accepted != n_done)
      @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);

    if (awaited_outcomes.size() != 0)
      $display("%0t ns: results missing: expected %0d more, actual 0",
               $time, awaited_outcomes.size());
    if (n_errors == 0 && awaited_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_cell.sv
hw/rtl/fixed_partition_allocator.sv
dv/fixed_partition_allocator_tb.sv
